/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define RAF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("property violated");

// expression must never be true outside reset
`define RAF_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define RAF_ASSERT(label, clk, rst, prop)
`define RAF_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

/* sv/raf_pkg.sv */
package raf_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned WINDOW_W = 6;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 6'd20;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* sv/raf_ram.sv */
module raf_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/raf_div.sv */
module raf_div #(
   parameter int unsigned NUM_W = 21,
   parameter int unsigned DEN_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           dividend,
   input  logic [DEN_W-1:0]           divisor,
   output raf_pkg::div_status_type    status,
   output logic [NUM_W-1:0]           quotient
);

   localparam int unsigned STEP_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] rem_shift;
   logic [DEN_W:0] rem_diff;
   logic           fits;

   // one quotient bit per cycle, msb first
   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

/* sv/running_average_filter.sv */
// channel | dir | signals                          | contents
// req     | in  | req_tvalid req_tready req_tdata  | sample [15:0]
// rsp     | out | rsp_tvalid rsp_tready rsp_tdata  | average [15:0]
// csr     | in  | csr_wen csr_wdata                | window_size [5:0]
//
// a beat passes through the sample memory read, read-modify-write of the sum,
// then the bit-serial divider, one bit a cycle.
// reset and a window write clear sum, slot and fill count at once; entries
// not yet written since are masked by the fill count, so no clearing pass.
// a finished average waits in the output register; the next sample is taken
// as soon as the divider result has moved there.
`include "assert_macros.svh"

module running_average_filter #(
   parameter int unsigned MAX_WINDOW = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] average
   input  logic        csr_wen,
   input  logic [5:0]  csr_wdata    // [5:0] window_size
);

   localparam int unsigned SAMPLE_W = raf_pkg::SAMPLE_W;
   localparam int unsigned WINDOW_W = raf_pkg::WINDOW_W;
   localparam int unsigned CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int unsigned SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned SUM_W    = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int unsigned CMP_W    = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_HOLD   = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [WINDOW_W-1:0] window_ff, window_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    fill_count_ff, fill_count_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]       eff_win;
   logic [CNT_W-1:0]       slot_inc;
   logic [SAMPLE_W-1:0]    old_sample;
   logic [SAMPLE_W-1:0]    rd_data;
   logic                   req_beat;
   logic                   out_free;
   logic                   div_start;
   logic [SUM_W-1:0]       quotient;
   raf_pkg::div_status_type div_stat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == ST_UPDATE);

   // zero acts as one, anything above the store depth as the depth
   always_comb begin
      if (window_ff == '0) begin
         eff_win = CNT_W'(1);
      end else if (CMP_W'(window_ff) > CMP_W'(MAX_WINDOW)) begin
         eff_win = CNT_W'(MAX_WINDOW);
      end else begin
         eff_win = CNT_W'(window_ff);
      end
   end

   assign slot_inc = CNT_W'(slot_ff) + CNT_W'(1);

   // while filling, the slot has not been written since the last clear
   assign old_sample = (fill_count_ff < eff_win) ? '0 : rd_data;

   raf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (div_start),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_beat),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   raf_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (fill_count_in),
      .status   (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      state_in      = state_ff;
      window_in     = window_ff;
      sum_in        = sum_ff;
      slot_in       = slot_ff;
      fill_count_in = fill_count_ff;
      sample_in     = sample_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               sample_in = req_tdata;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            sum_in  = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
            slot_in = (slot_inc >= eff_win) ? '0 : SLOT_W'(slot_inc);
            if (fill_count_ff < eff_win) begin
               fill_count_in = fill_count_ff + CNT_W'(1);
            end
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = quotient[SAMPLE_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wen) begin
         window_in     = csr_wdata;
         sum_in        = '0;
         slot_in       = '0;
         fill_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= raf_pkg::WINDOW_RESET;
         sum_ff        <= '0;
         slot_ff       <= '0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         sum_ff        <= sum_in;
         slot_ff       <= slot_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RAF_ASSERT(a_fill_within_window, clock, reset, fill_count_ff <= eff_win)
   `RAF_ASSERT(a_slot_within_window, clock, reset, CNT_W'(slot_ff) < eff_win)
   `RAF_ASSERT(a_beat_starts_update, clock, reset, req_beat |=> state_ff == ST_UPDATE)
   `RAF_ASSERT_NEVER(a_div_done_off_state, clock, reset, div_stat.done && state_ff != ST_DIVIDE)
   `RAF_ASSERT_NEVER(a_div_busy_off_state, clock, reset, div_stat.busy && state_ff != ST_DIVIDE)

endmodule

/* test/running_average_filter_checker.sv */
`timescale 1ns / 1ps

module running_average_filter_checker #(
   parameter int unsigned MAX_WINDOW = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] sample
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [15:0]         rsp_tdata,   // [15:0] average
   input  logic                csr_wen,
   input  logic [5:0]          csr_wdata,   // [5:0] window_size
   output int unsigned         error_count,
   output int unsigned         averages_pending
);

   localparam int unsigned SAMPLE_W = raf_pkg::SAMPLE_W;
   localparam int unsigned SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int unsigned SUM_W    = SAMPLE_W + $clog2(MAX_WINDOW);

   logic [SAMPLE_W-1:0]          window_store [MAX_WINDOW];
   logic [SUM_W-1:0]             window_sum;
   logic [SLOT_W-1:0]            write_slot;
   logic [CNT_W-1:0]             fill_count;
   logic [raf_pkg::WINDOW_W-1:0] window_size;
   logic [SAMPLE_W-1:0]          averages_due [$];

   task automatic clear_window();
      foreach (window_store[i]) window_store[i] = '0;
      window_sum = '0;
      write_slot = '0;
      fill_count = '0;
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [SAMPLE_W-1:0] next_average(input logic [SAMPLE_W-1:0] sample);
      int unsigned       win;
      logic [SLOT_W-1:0] slot;
      win = 32'(window_size);
      // zero acts as one, anything past the store depth as the full store
      if (win == 0) win = 1;
      if (win > MAX_WINDOW) win = MAX_WINDOW;
      slot = (32'(write_slot) >= win) ? '0 : write_slot;
      window_sum = window_sum - SUM_W'(window_store[slot]) + SUM_W'(sample);
      window_store[slot] = sample;
      write_slot = (32'(slot) + 32'd1 >= win) ? '0 : slot + SLOT_W'(1);
      if (32'(fill_count) < win) fill_count = fill_count + CNT_W'(1);
      return SAMPLE_W'(window_sum / SUM_W'(fill_count));
   endfunction

   always @(posedge clock) begin : watch
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         window_size = raf_pkg::WINDOW_RESET;
         clear_window();
         averages_due.delete();
      end else begin
         if (csr_wen) begin
            window_size = csr_wdata;
            clear_window();
         end
         if (req_tvalid && req_tready)
            averages_due.push_back(next_average(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (averages_due.size() == 0) begin
               report_mismatch("average beat with none due", rsp_tdata, '0);
            end else begin
               want = averages_due.pop_front();
               if (rsp_tdata !== want) report_mismatch("average", rsp_tdata, want);
            end
         end
      end
      averages_pending <= averages_due.size();
   end

endmodule

/* test/running_average_filter_test.sv */
`timescale 1ns / 1ps

module running_average_filter_test;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [15:0]                  req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [15:0]                  rsp_tdata;
   logic                         csr_wen = 1'b0;
   logic [raf_pkg::WINDOW_W-1:0] csr_wdata = '0;

   int unsigned error_count;
   int unsigned averages_pending;
   int unsigned req_gap_max = 10;
   int unsigned rsp_gap_max = 10;
   int unsigned hold_rsp_req = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   running_average_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   running_average_filter_checker average_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_wen          (csr_wen),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .averages_pending (averages_pending)
   );

   // valid stays up after a beat until the next call decides whether to gap
   task automatic send_sample(input logic [15:0] sample);
      int unsigned gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(req_gap_max, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_averages();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (averages_pending != 0);
   endtask

   task automatic write_window(input logic [raf_pkg::WINDOW_W-1:0] size);
      csr_wen   <= 1'b1;
      csr_wdata <= size;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   function automatic logic [15:0] random_sample();
      case ($urandom_range(9, 0))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(16'hFFFF, 16'hF000));
         4:       return 16'($urandom_range(15, 0));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin : receiver
      int unsigned gap;
      int unsigned holds_done;
      holds_done = 0;
      do @(posedge clock); while (reset);
      forever begin
         gap = (rsp_gap_max == 0) ? 0 : $urandom_range(rsp_gap_max, 0);
         // long hold-off so the block backs up and stalls its input
         if (hold_rsp_req != holds_done) begin
            holds_done = hold_rsp_req;
            gap += 300;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned phase;
      int unsigned count;
      bit          heavy;
      logic [raf_pkg::WINDOW_W-1:0] size;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // window from reset, extremes and alternating bit patterns
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      send_sample(16'h0001);
      send_sample(16'hFFFF);
      send_sample(16'hFFFF);
      send_sample(16'hFFFE);
      drain_averages();
      // zero window behaves as one
      write_window(6'd0);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      send_sample(16'h8000);
      drain_averages();
      // oversized window clamps to the store depth
      write_window(6'd63);
      send_sample(16'hFFFF);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      drain_averages();
      write_window(6'd1);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0007);
      drain_averages();

      sent  = 0;
      phase = 0;
      while (sent < 1950) begin
         heavy = 1'b0;
         case (phase % 8)
            0: size = 6'd32;
            1: size = 6'd1;
            2: size = 6'd33;
            3: size = 6'd0;
            4: size = 6'($urandom_range(32, 1));
            5: size = 6'($urandom_range(63, 0));
            6: begin
               size  = 6'd32;
               heavy = 1'b1;
            end
            default: size = 6'($urandom_range(8, 1));
         endcase
         req_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 10;
         rsp_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 10;
         drain_averages();
         write_window(size);
         count = $urandom_range(200, 60);
         if (count > 1950 - sent) count = 1950 - sent;
         for (int unsigned i = 0; i < count; i++) begin
            if (i == count / 2 && phase % 8 == 3) hold_rsp_req++;
            if (i == count / 2 && phase % 8 == 5) drain_averages();
            // mostly full-scale samples push the sum to the top of its range
            if (heavy)
               send_sample(($urandom_range(9, 0) == 0) ? 16'($urandom) : 16'hFFFF);
            else
               send_sample(random_sample());
         end
         sent += count;
         phase++;
      end

      drain_averages();
      repeat (40) @(posedge clock);
      if (error_count == 0 && averages_pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
